// ===== hdl/sdll_pkg.sv =====
package sdll_pkg;

    // Pool geometry
    localparam int NODE_COUNT = 32;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int LINK_W     = $clog2(NODE_COUNT + 1);
    localparam int CNT_W      = LINK_W;

    // Field widths
    localparam int OP_W   = 2;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int SLOT_W = 8;
    localparam int ACT_W  = 6;

    localparam logic [ACT_W-1:0]  ACTIVE_RESET = 6'd32;
    localparam logic [LINK_W-1:0] NULL_LINK    = '1;
    localparam logic [VAL_W-1:0]  FREE_VALUE   = '1;
    localparam logic [SLOT_W-1:0] NO_SLOT      = '1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2,
        OP_FIRST  = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_INVALID   = 2'd3
    } t_status;

    typedef struct packed {
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] next;
    } t_links;

    // Request from the list controller to the node store
    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             val_we;
        logic             link_we;
        logic [IDX_W-1:0] wr_addr;
        logic [VAL_W-1:0] wr_value;
        t_links           wr_links;
        logic             occ_clr;
        logic [IDX_W-1:0] occ_addr;
        logic             clear_all;
    } t_mem_cmd;

    // Registered read data; a free node reads as an all-ones value with null links
    typedef struct packed {
        logic [VAL_W-1:0] value;
        t_links           links;
    } t_mem_rsp;

    typedef struct packed {
        t_status           status;
        logic [VAL_W-1:0]  value;
        logic [SLOT_W-1:0] slot;
    } t_result;

    // Clamp the capacity register into 1..NODE_COUNT
    function automatic logic [CNT_W-1:0] eff_size(input logic [ACT_W-1:0] act);
        logic [CNT_W-1:0] s;
        if (act == '0) begin
            s = CNT_W'(1);
        end else if (int'(act) > NODE_COUNT) begin
            s = CNT_W'(NODE_COUNT);
        end else begin
            s = CNT_W'(act);
        end
        return s;
    endfunction

    function automatic logic [SLOT_W-1:0] to_slot(input logic [LINK_W-1:0] link);
        logic [SLOT_W-1:0] s;
        if (link == NULL_LINK) begin
            s = NO_SLOT;
        end else begin
            s = SLOT_W'(link);
        end
        return s;
    endfunction

endpackage

// ===== hdl/sdll_if.sv =====
interface sdll_in_if;
    logic                          valid;
    logic                          ready;
    logic [sdll_pkg::OP_W-1:0]     op;
    logic [sdll_pkg::VAL_W-1:0]    value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface sdll_out_if;
    logic                          valid;
    logic                          ready;
    logic [sdll_pkg::ST_W-1:0]     status;
    logic [sdll_pkg::VAL_W-1:0]    result_value;
    logic [sdll_pkg::SLOT_W-1:0]   slot_index;

    modport source (output valid, output status, output result_value, output slot_index,
                    input ready);
    modport sink   (input valid, input status, input result_value, input slot_index,
                    output ready);
endinterface

// ===== hdl/sdll_store.sv =====
module sdll_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sdll_pkg::t_mem_cmd i_cmd,
    output sdll_pkg::t_mem_rsp o_rsp,
    output logic [sdll_pkg::IDX_W-1:0] o_free_slot
);

    logic [sdll_pkg::VAL_W-1:0]    r_value_mem [sdll_pkg::NODE_COUNT];
    sdll_pkg::t_links              r_link_mem  [sdll_pkg::NODE_COUNT];
    logic [sdll_pkg::NODE_COUNT-1:0] r_occ;
    logic                          r_rd_occ;
    logic [sdll_pkg::VAL_W-1:0]    r_rd_value;
    sdll_pkg::t_links              r_rd_links;

    // Value memory: write on allocation, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.val_we) begin
            r_value_mem[i_cmd.wr_addr] <= i_cmd.wr_value;
        end
        r_rd_value <= r_value_mem[i_cmd.rd_addr];
    end

    // Link memory: prev and next links of each node
    always_ff @(posedge i_clk) begin
        if (i_cmd.link_we) begin
            r_link_mem[i_cmd.wr_addr] <= i_cmd.wr_links;
        end
        r_rd_links <= r_link_mem[i_cmd.rd_addr];
    end

    // Occupancy bits: set on allocation, drop on delete, clear all on reset or resize
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            r_occ    <= '0;
            r_rd_occ <= 1'b0;
        end else begin
            if (i_cmd.val_we) begin
                r_occ[i_cmd.wr_addr] <= 1'b1;
            end
            if (i_cmd.occ_clr) begin
                r_occ[i_cmd.occ_addr] <= 1'b0;
            end
            r_rd_occ <= r_occ[i_cmd.rd_addr];
        end
    end

    // Free nodes read as all-ones value with null links
    always_comb begin
        if (r_rd_occ) begin
            o_rsp.value = r_rd_value;
            o_rsp.links = r_rd_links;
        end else begin
            o_rsp.value      = sdll_pkg::FREE_VALUE;
            o_rsp.links.prev = sdll_pkg::NULL_LINK;
            o_rsp.links.next = sdll_pkg::NULL_LINK;
        end
    end

    // Lowest free slot
    always_comb begin
        o_free_slot = '0;
        for (int i = sdll_pkg::NODE_COUNT - 1; i >= 0; i--) begin
            if (!r_occ[i]) begin
                o_free_slot = sdll_pkg::IDX_W'(i);
            end
        end
    end

endmodule

// ===== hdl/static_pool_doubly_linked_list.sv =====
// Path from accept to result valid: a rejected item or an empty list goes straight to S_EMIT;
// first reads the head in S_FIRST; insert passes S_ALLOC, then S_INS_FIX if there was a head;
// find walks in S_WALK; delete walks, then relinks in S_FIX_P, S_FIX_N; S_EMIT waits on o_rsp.
// Throughput: one item at a time, one node read per cycle during the walk; the next item is
// taken the cycle after the result is registered, even while that result waits.
// Reset (synchronous, active low) empties the list, capacity 32; a capacity write empties it.
module static_pool_doubly_linked_list (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sdll_pkg::ACT_W-1:0] i_cfg_wdata,
    sdll_in_if.sink                    i_req,
    sdll_out_if.source                 o_rsp
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_ALLOC   = 8'b0000_0010,
        S_INS_FIX = 8'b0000_0100,
        S_WALK    = 8'b0000_1000,
        S_FIX_P   = 8'b0001_0000,
        S_FIX_N   = 8'b0010_0000,
        S_FIRST   = 8'b0100_0000,
        S_EMIT    = 8'b1000_0000
    } t_state;

    t_state                          r_state, n_state;
    logic [sdll_pkg::ACT_W-1:0]      r_active, n_active;
    logic [sdll_pkg::LINK_W-1:0]     r_head, n_head;
    logic [sdll_pkg::CNT_W-1:0]      r_count, n_count;
    sdll_pkg::t_op                   r_op, n_op;
    logic [sdll_pkg::VAL_W-1:0]      r_val, n_val;
    logic [sdll_pkg::LINK_W-1:0]     r_idx, n_idx;
    logic [sdll_pkg::CNT_W-1:0]      r_step, n_step;
    logic [sdll_pkg::LINK_W-1:0]     r_prev, n_prev;
    logic [sdll_pkg::LINK_W-1:0]     r_next, n_next;
    sdll_pkg::t_result               r_res, n_res;
    logic                            r_out_valid, n_out_valid;
    sdll_pkg::t_result               r_out, n_out;

    sdll_pkg::t_mem_cmd              mem_cmd;
    sdll_pkg::t_mem_rsp              mem_rsp;
    logic [sdll_pkg::IDX_W-1:0]      free_slot;
    logic [sdll_pkg::CNT_W-1:0]      size;
    logic [sdll_pkg::CNT_W-1:0]      step_inc;
    logic [sdll_pkg::LINK_W-1:0]     walk_next;

    sdll_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (mem_cmd),
        .o_rsp       (mem_rsp),
        .o_free_slot (free_slot)
    );

    assign size      = sdll_pkg::eff_size(r_active);
    assign step_inc  = r_step + sdll_pkg::CNT_W'(1);
    assign walk_next = (mem_rsp.links.next < size) ? mem_rsp.links.next : sdll_pkg::NULL_LINK;

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.result_value = r_out.value;
    assign o_rsp.slot_index   = r_out.slot;

    // Sequence one operation over the node store
    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_head      = r_head;
        n_count     = r_count;
        n_op        = r_op;
        n_val       = r_val;
        n_idx       = r_idx;
        n_step      = r_step;
        n_prev      = r_prev;
        n_next      = r_next;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;

        mem_cmd          = '0;
        mem_cmd.rd_addr  = r_idx[sdll_pkg::IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op  = sdll_pkg::t_op'(i_req.op);
                    n_val = i_req.value;
                    n_res.status = sdll_pkg::ST_NOT_FOUND;
                    n_res.value  = sdll_pkg::FREE_VALUE;
                    n_res.slot   = sdll_pkg::NO_SLOT;
                    if (sdll_pkg::t_op'(i_req.op) == sdll_pkg::OP_FIRST) begin
                        if (r_count == '0 || r_head >= size) begin
                            n_state = S_EMIT;
                        end else begin
                            mem_cmd.rd_addr = r_head[sdll_pkg::IDX_W-1:0];
                            n_state         = S_FIRST;
                        end
                    end else if (i_req.value == sdll_pkg::FREE_VALUE) begin
                        n_res.status = sdll_pkg::ST_INVALID;
                        n_state      = S_EMIT;
                    end else if (sdll_pkg::t_op'(i_req.op) == sdll_pkg::OP_INSERT) begin
                        if (r_count >= size) begin
                            n_res.status = sdll_pkg::ST_FULL;
                            n_state      = S_EMIT;
                        end else begin
                            n_state = S_ALLOC;
                        end
                    end else begin
                        if (r_count == '0 || r_head >= size) begin
                            n_state = S_EMIT;
                        end else begin
                            mem_cmd.rd_addr = r_head[sdll_pkg::IDX_W-1:0];
                            n_idx           = r_head;
                            n_step          = '0;
                            n_state         = S_WALK;
                        end
                    end
                end
            end

            // Write the new node at the lowest free slot, fetch the old head
            S_ALLOC: begin
                mem_cmd.val_we        = 1'b1;
                mem_cmd.link_we       = 1'b1;
                mem_cmd.wr_addr       = free_slot;
                mem_cmd.wr_value      = r_val;
                mem_cmd.wr_links.prev = sdll_pkg::NULL_LINK;
                mem_cmd.wr_links.next = r_head;
                n_idx = sdll_pkg::LINK_W'(free_slot);
                n_res.status = sdll_pkg::ST_OK;
                n_res.value  = r_val;
                n_res.slot   = sdll_pkg::SLOT_W'(free_slot);
                if (r_head < size) begin
                    mem_cmd.rd_addr = r_head[sdll_pkg::IDX_W-1:0];
                    n_state         = S_INS_FIX;
                end else begin
                    n_head  = sdll_pkg::LINK_W'(free_slot);
                    n_count = r_count + sdll_pkg::CNT_W'(1);
                    n_state = S_EMIT;
                end
            end

            // Point the old head back at the new node
            S_INS_FIX: begin
                mem_cmd.link_we       = 1'b1;
                mem_cmd.wr_addr       = r_head[sdll_pkg::IDX_W-1:0];
                mem_cmd.wr_links.prev = r_idx;
                mem_cmd.wr_links.next = mem_rsp.links.next;
                n_head  = r_idx;
                n_count = r_count + sdll_pkg::CNT_W'(1);
                n_state = S_EMIT;
            end

            // Compare one node per cycle, advance along the next links
            S_WALK: begin
                if (mem_rsp.value == r_val) begin
                    n_res.status = sdll_pkg::ST_OK;
                    n_res.value  = r_val;
                    n_res.slot   = sdll_pkg::to_slot(r_idx);
                    if (r_op == sdll_pkg::OP_DELETE) begin
                        mem_cmd.occ_clr  = 1'b1;
                        mem_cmd.occ_addr = r_idx[sdll_pkg::IDX_W-1:0];
                        n_count = r_count - sdll_pkg::CNT_W'(1);
                        n_prev  = mem_rsp.links.prev;
                        n_next  = walk_next;
                        if (mem_rsp.links.prev >= size) begin
                            n_head = walk_next;
                            if (walk_next != sdll_pkg::NULL_LINK) begin
                                mem_cmd.rd_addr = walk_next[sdll_pkg::IDX_W-1:0];
                                n_prev          = sdll_pkg::NULL_LINK;
                                n_state         = S_FIX_N;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end else begin
                            mem_cmd.rd_addr = mem_rsp.links.prev[sdll_pkg::IDX_W-1:0];
                            n_state         = S_FIX_P;
                        end
                        if (r_count == sdll_pkg::CNT_W'(1)) begin
                            n_head = sdll_pkg::NULL_LINK;
                        end
                    end else begin
                        n_state = S_EMIT;
                    end
                end else if (step_inc >= size || mem_rsp.links.next >= size) begin
                    n_state = S_EMIT;
                end else begin
                    mem_cmd.rd_addr = mem_rsp.links.next[sdll_pkg::IDX_W-1:0];
                    n_idx           = mem_rsp.links.next;
                    n_step          = step_inc;
                end
            end

            // Relink the previous node past the removed one
            S_FIX_P: begin
                mem_cmd.link_we       = 1'b1;
                mem_cmd.wr_addr       = r_prev[sdll_pkg::IDX_W-1:0];
                mem_cmd.wr_links.prev = mem_rsp.links.prev;
                mem_cmd.wr_links.next = r_next;
                if (r_next != sdll_pkg::NULL_LINK) begin
                    mem_cmd.rd_addr = r_next[sdll_pkg::IDX_W-1:0];
                    n_state         = S_FIX_N;
                end else begin
                    n_state = S_EMIT;
                end
            end

            // Relink the following node back
            S_FIX_N: begin
                mem_cmd.link_we       = 1'b1;
                mem_cmd.wr_addr       = r_next[sdll_pkg::IDX_W-1:0];
                mem_cmd.wr_links.prev = r_prev;
                mem_cmd.wr_links.next = mem_rsp.links.next;
                n_state = S_EMIT;
            end

            S_FIRST: begin
                n_res.status = sdll_pkg::ST_OK;
                n_res.value  = mem_rsp.value;
                n_res.slot   = sdll_pkg::to_slot(r_head);
                n_state      = S_EMIT;
            end

            // Hand the result to the output register once it is free
            S_EMIT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Capacity write empties the pool
        if (i_cfg_we) begin
            n_active          = i_cfg_wdata;
            n_head            = sdll_pkg::NULL_LINK;
            n_count           = '0;
            mem_cmd.clear_all = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= sdll_pkg::ACTIVE_RESET;
            r_head      <= sdll_pkg::NULL_LINK;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_val  <= n_val;
        r_idx  <= n_idx;
        r_step <= n_step;
        r_prev <= n_prev;
        r_next <= n_next;
        r_res  <= n_res;
        r_out  <= n_out;
    end

endmodule
